[rtl/fea_pkg.sv]
package fea_pkg;

  localparam int POOL_UNITS  = 4096;
  localparam int MAX_EXTENTS = 64;
  localparam int UNIT_BYTES  = 16;

  localparam int AW         = $clog2(POOL_UNITS);
  localparam int LW         = $clog2(POOL_UNITS + 1);
  localparam int IW         = $clog2(MAX_EXTENTS);
  localparam int CW         = $clog2(MAX_EXTENTS + 1);
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int BW         = 17;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic          action;
    logic [BW-1:0] byte_count;
    logic [11:0]   data_address;
  } req_t;

  typedef struct packed {
    logic [11:0] result_address;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [LW-1:0] len;
  } ext_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_END,
    S_F_BL,
    S_F_LEN,
    S_F_RD,
    S_F_CHK,
    S_F_END,
    S_D_RD,
    S_D_WR,
    S_I_RD,
    S_I_WR,
    S_RESP
  } state_t;

endpackage

[rtl/free_extent_allocator.sv]
// Free extent allocator.
// Request channel: drive request and pulse start while busy is low; the word
// is taken at that edge and busy stays high until the result is shown.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver must take it then, it cannot stall the block.
// Configuration: cfg_data selects first fit (0) or best fit (1); cfg_ready
// is always high, write only while busy is low.
// Each request walks the extent table through one registered read port, with a
// read state and a check state per extent visited; removing or inserting a
// table entry moves each entry with a read state and a write state.
// One request is in flight at a time.
// Reset: synchronous, active high; the cycle after reset writes the single
// pool extent into the table, busy is high for that one cycle.
module free_extent_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fea_pkg::req_t        request,
  output logic                 done,
  output fea_pkg::res_t        result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  fea_pkg::state_t state, state_next;

  fea_pkg::ext_t ext_mem [fea_pkg::MAX_EXTENTS];
  logic [fea_pkg::LW-1:0] blk_mem [fea_pkg::POOL_UNITS];

  fea_pkg::ext_t          rdata;
  logic [fea_pkg::LW-1:0] brdata;
  logic [fea_pkg::IW-1:0] raddr, waddr;
  logic                   we, bwe;
  fea_pkg::ext_t          wdata;
  logic [fea_pkg::AW-1:0] baddr;

  logic                   fit;
  logic [fea_pkg::CW-1:0] count, count_next;
  logic [fea_pkg::CW-1:0] idx, idx_next;
  logic [fea_pkg::CW-1:0] sel_idx, sel_idx_next;
  logic                   found, found_next;
  logic [fea_pkg::AW-1:0] sel_start, sel_start_next;
  logic [fea_pkg::LW-1:0] sel_len, sel_len_next;
  logic [fea_pkg::LW-1:0] need, need_next;
  logic [fea_pkg::AW-1:0] hdr, hdr_next;
  logic [fea_pkg::LW-1:0] blen, blen_next;
  logic                   has_prev, has_prev_next;
  logic                   has_next, has_next_next;
  fea_pkg::ext_t          prv, prv_next;
  fea_pkg::ext_t          nxt, nxt_next;
  fea_pkg::res_t          res, res_next;

  logic [fea_pkg::BW:0]   bc_round;
  logic [fea_pkg::LW-1:0] sel_rem;
  logic [fea_pkg::AW-1:0] a_hdr;
  logic [fea_pkg::LW-1:0] prev_end, hdr_end, room;
  logic                   lo, hi;

  assign busy      = (state != fea_pkg::S_IDLE);
  assign done      = (state == fea_pkg::S_RESP);
  assign result    = res;
  assign cfg_ready = 1'b1;

  assign bc_round = {1'b0, request.byte_count} + (fea_pkg::BW+1)'(fea_pkg::UNIT_BYTES - 1);
  assign sel_rem  = sel_len - need;
  assign a_hdr    = sel_start + sel_rem[fea_pkg::AW-1:0];
  assign prev_end = {1'b0, prv.start} + prv.len;
  assign hdr_end  = {1'b0, hdr} + blen;
  assign room     = fea_pkg::LW'(fea_pkg::POOL_UNITS) - {1'b0, hdr};
  assign lo       = has_prev && (prev_end == {1'b0, hdr});
  assign hi       = has_next && (hdr_end == {1'b0, nxt.start});

  assign raddr = (state == fea_pkg::S_I_RD) ? fea_pkg::IW'(idx - 1'b1) : idx[fea_pkg::IW-1:0];
  assign baddr = (state == fea_pkg::S_A_END) ? a_hdr : hdr;

  always_ff @(posedge clk) begin
    if (we) begin
      ext_mem[waddr] <= wdata;
    end
    rdata <= ext_mem[raddr];
    if (bwe) begin
      blk_mem[baddr] <= need;
    end
    brdata <= blk_mem[baddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fea_pkg::S_INIT;
      count <= fea_pkg::CW'(1);
      fit   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        fit <= cfg_data;
      end
    end
    idx       <= idx_next;
    sel_idx   <= sel_idx_next;
    found     <= found_next;
    sel_start <= sel_start_next;
    sel_len   <= sel_len_next;
    need      <= need_next;
    hdr       <= hdr_next;
    blen      <= blen_next;
    has_prev  <= has_prev_next;
    has_next  <= has_next_next;
    prv       <= prv_next;
    nxt       <= nxt_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    sel_idx_next   = sel_idx;
    found_next     = found;
    sel_start_next = sel_start;
    sel_len_next   = sel_len;
    need_next      = need;
    hdr_next       = hdr;
    blen_next      = blen;
    has_prev_next  = has_prev;
    has_next_next  = has_next;
    prv_next       = prv;
    nxt_next       = nxt;
    res_next       = res;
    we             = 1'b0;
    bwe            = 1'b0;
    waddr          = idx[fea_pkg::IW-1:0];
    wdata          = rdata;
    case (state)
      fea_pkg::S_INIT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = '{start: '0, len: fea_pkg::LW'(fea_pkg::POOL_UNITS)};
        count_next = fea_pkg::CW'(1);
        state_next = fea_pkg::S_IDLE;
      end
      fea_pkg::S_IDLE: begin
        if (start) begin
          res_next = '{result_address: '0, status: fea_pkg::ST_IGNORED};
          idx_next = '0;
          if (request.action == fea_pkg::ACT_ALLOC) begin
            found_next = 1'b0;
            need_next  = fea_pkg::LW'(bc_round >> fea_pkg::UNIT_SHIFT) + 1'b1;
            state_next = (request.byte_count == '0) ? fea_pkg::S_RESP : fea_pkg::S_A_RD;
          end else begin
            hdr_next      = request.data_address - 1'b1;
            has_prev_next = 1'b0;
            has_next_next = 1'b0;
            state_next    = (request.data_address == '0) ? fea_pkg::S_RESP : fea_pkg::S_F_BL;
          end
        end
      end
      fea_pkg::S_A_RD: begin
        state_next = (idx == count) ? fea_pkg::S_A_END : fea_pkg::S_A_CHK;
      end
      fea_pkg::S_A_CHK: begin
        state_next = fea_pkg::S_A_RD;
        idx_next   = idx + 1'b1;
        if (rdata.len >= need) begin
          if (!fit || rdata.len == need) begin
            found_next     = 1'b1;
            sel_idx_next   = idx;
            sel_start_next = rdata.start;
            sel_len_next   = rdata.len;
            state_next     = fea_pkg::S_A_END;
          end else if (!found || rdata.len < sel_len) begin
            found_next     = 1'b1;
            sel_idx_next   = idx;
            sel_start_next = rdata.start;
            sel_len_next   = rdata.len;
          end
        end
      end
      fea_pkg::S_A_END: begin
        if (!found) begin
          res_next.status = fea_pkg::ST_NOSPACE;
          state_next      = fea_pkg::S_RESP;
        end else begin
          bwe      = 1'b1;
          res_next = '{result_address: baddr + 1'b1, status: fea_pkg::ST_DONE};
          if (sel_len == need) begin
            idx_next   = sel_idx + 1'b1;
            state_next = fea_pkg::S_D_RD;
          end else begin
            we         = 1'b1;
            waddr      = sel_idx[fea_pkg::IW-1:0];
            wdata      = '{start: sel_start, len: sel_rem};
            state_next = fea_pkg::S_RESP;
          end
        end
      end
      fea_pkg::S_F_BL: begin
        state_next = fea_pkg::S_F_LEN;
      end
      fea_pkg::S_F_LEN: begin
        blen_next  = brdata;
        state_next = (brdata == '0 || brdata > room) ? fea_pkg::S_RESP : fea_pkg::S_F_RD;
      end
      fea_pkg::S_F_RD: begin
        state_next = (idx == count) ? fea_pkg::S_F_END : fea_pkg::S_F_CHK;
      end
      fea_pkg::S_F_CHK: begin
        if (rdata.start <= hdr) begin
          prv_next      = rdata;
          has_prev_next = 1'b1;
          idx_next      = idx + 1'b1;
          state_next    = fea_pkg::S_F_RD;
        end else begin
          nxt_next      = rdata;
          has_next_next = 1'b1;
          state_next    = fea_pkg::S_F_END;
        end
      end
      fea_pkg::S_F_END: begin
        state_next = fea_pkg::S_RESP;
        if ((has_prev && prev_end > {1'b0, hdr}) ||
            (has_next && hdr_end > {1'b0, nxt.start})) begin
          res_next.status = fea_pkg::ST_IGNORED;
        end else begin
          res_next.status = fea_pkg::ST_DONE;
          if (lo) begin
            we    = 1'b1;
            waddr = fea_pkg::IW'(idx - 1'b1);
            wdata = '{start: prv.start, len: prv.len + blen + (hi ? nxt.len : '0)};
            if (hi) begin
              idx_next   = idx + 1'b1;
              state_next = fea_pkg::S_D_RD;
            end
          end else if (hi) begin
            we    = 1'b1;
            wdata = '{start: hdr, len: nxt.len + blen};
          end else if (count >= fea_pkg::CW'(fea_pkg::MAX_EXTENTS)) begin
            res_next.status = fea_pkg::ST_FULL;
          end else begin
            sel_idx_next = idx;
            idx_next     = count;
            state_next   = fea_pkg::S_I_RD;
          end
        end
      end
      fea_pkg::S_D_RD: begin
        if (idx == count) begin
          count_next = count - 1'b1;
          state_next = fea_pkg::S_RESP;
        end else begin
          state_next = fea_pkg::S_D_WR;
        end
      end
      fea_pkg::S_D_WR: begin
        we         = 1'b1;
        waddr      = fea_pkg::IW'(idx - 1'b1);
        idx_next   = idx + 1'b1;
        state_next = fea_pkg::S_D_RD;
      end
      fea_pkg::S_I_RD: begin
        if (idx == sel_idx) begin
          we         = 1'b1;
          wdata      = '{start: hdr, len: blen};
          count_next = count + 1'b1;
          state_next = fea_pkg::S_RESP;
        end else begin
          state_next = fea_pkg::S_I_WR;
        end
      end
      fea_pkg::S_I_WR: begin
        we         = 1'b1;
        idx_next   = idx - 1'b1;
        state_next = fea_pkg::S_I_RD;
      end
      fea_pkg::S_RESP: begin
        state_next = fea_pkg::S_IDLE;
      end
      default: begin
        state_next = fea_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fea_pkg::CW'(fea_pkg::MAX_EXTENTS))
    else $error("extent count above table depth");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result shown for more than one cycle");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request taken without going busy");

  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    done && result.status != fea_pkg::ST_DONE |-> result.result_address == '0)
    else $error("failed request returned an address");

endmodule
